// ----- src/sravm_pkg.sv -----
// shared types, constants and codes for the sensor running average monitor
package sravm_pkg;

  localparam int MAX_SENSORS = 16;
  localparam int WINDOW      = 8;

  localparam int DATA_W      = 16;
  localparam int CNT_W       = 4;
  localparam int IDX_W       = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int WPTR_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int STORE_DEPTH = MAX_SENSORS * WINDOW;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SUM_W       = DATA_W + WPTR_W + 1;
  localparam int MAG_W       = SUM_W - 1;
  localparam int DIV_CNT_W   = $clog2(MAG_W);

  localparam logic [1:0] MODE_REGISTER = 2'd0;
  localparam logic [1:0] MODE_READING  = 2'd1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HOT     = 3'd1;
  localparam logic [2:0] ST_COLD    = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic REG_MAX_TEMP = 1'b0;
  localparam logic REG_MIN_TEMP = 1'b1;

  localparam logic signed [DATA_W-1:0] MAX_TEMP_RST = 16'sd3200;
  localparam logic signed [DATA_W-1:0] MIN_TEMP_RST = 16'sd1920;

  typedef struct packed {
    logic [1:0]               mode;
    logic [DATA_W-1:0]        sensor_in;
    logic [DATA_W-1:0]        room_in;
    logic signed [DATA_W-1:0] reading_in;
  } in_word_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [DATA_W-1:0]        room_out;
    logic signed [DATA_W-1:0] average_out;
    logic [CNT_W-1:0]         count_out;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SUM,
    S_DIV,
    S_FIN,
    S_RESULT
  } fsm_e;

endpackage

// ----- src/sensor_running_average_monitor.sv -----
// sensor table with per-sensor reading ring, running average and threshold check
// sequence: a register or query word runs a serial table search of up to
//   MAX_SENSORS entries, then decide and result; a reading word adds accumulation
//   over the single store read port, a bit-serial divider over MAG_W (19) quotient
//   bits and a final step to sign the quotient
// throughput: one word in flight; the next is taken once the result sits in the
//   output register
// reset: table empty, counts and pointers zero, thresholds 3200 and 1920
module sensor_running_average_monitor
  import sravm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_word_t                 in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_word_t                out_word_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_data_i
);

  fsm_e state_q, state_d;

  in_word_t  word_q;
  out_word_t res_q;
  out_word_t res_dec;
  out_word_t out_q;
  logic      out_valid_q;

  logic signed [DATA_W-1:0] max_q, min_q;

  logic                entry_valid_q  [MAX_SENSORS];
  logic [DATA_W-1:0]   entry_sensor_q [MAX_SENSORS];
  logic [DATA_W-1:0]   entry_room_q   [MAX_SENSORS];
  logic [CNT_W-1:0]    count_q        [MAX_SENSORS];
  logic [WPTR_W-1:0]   wptr_q         [MAX_SENSORS];

  logic signed [DATA_W-1:0] store_q [STORE_DEPTH];
  logic signed [DATA_W-1:0] rd_data_q;

  logic [IDX_W-1:0]     idx_q, free_q;
  logic                 hit_q, free_vld_q;
  logic [CNT_W-1:0]     n_q, rd_idx_q;
  logic                 rd_vld_q;
  logic signed [SUM_W-1:0] acc_q, hi_q, lo_q;
  logic [MAG_W-1:0]     dvd_q;
  logic [CNT_W-1:0]     rem_q;
  logic                 neg_q;
  logic [DIV_CNT_W-1:0] step_q;

  // control decode
  logic in_ready, out_free, out_load, store_we, entry_we, rd_en;
  logic match, last_idx, sum_done, div_last;
  logic mode_reg, mode_read;

  logic [IDX_W-1:0]    slot;
  logic [CNT_W-1:0]    cnt_cur, cnt_new;
  logic [WPTR_W-1:0]   wptr_cur, wptr_new;
  logic [STORE_AW-1:0] base, wr_addr, rd_addr;
  logic signed [SUM_W-1:0] acc_neg;
  logic [MAG_W-1:0]    acc_mag, quo_neg;
  logic [CNT_W:0]      trial;
  logic                ge;

  assign mode_reg  = (word_q.mode == MODE_REGISTER);
  assign mode_read = (word_q.mode == MODE_READING);
  assign match     = entry_valid_q[idx_q] && (entry_sensor_q[idx_q] == word_q.sensor_in);
  assign last_idx  = (idx_q == IDX_W'(MAX_SENSORS - 1));
  assign sum_done  = (rd_idx_q == n_q) && !rd_vld_q;
  assign div_last  = (step_q == '0);
  assign out_free  = !out_valid_q || out_ready_i;

  assign slot     = hit_q ? idx_q : free_q;
  assign cnt_cur  = count_q[idx_q];
  assign cnt_new  = (cnt_cur < CNT_W'(WINDOW)) ? cnt_cur + CNT_W'(1) : cnt_cur;
  assign wptr_cur = wptr_q[idx_q];
  assign wptr_new = (wptr_cur == WPTR_W'(WINDOW - 1)) ? '0 : wptr_cur + WPTR_W'(1);
  assign base     = STORE_AW'(idx_q) * STORE_AW'(WINDOW);
  assign wr_addr  = base + STORE_AW'(wptr_cur);
  assign rd_addr  = base + STORE_AW'(rd_idx_q);

  assign acc_neg  = -acc_q;
  assign acc_mag  = acc_q[SUM_W-1] ? acc_neg[MAG_W-1:0] : acc_q[MAG_W-1:0];
  assign quo_neg  = -dvd_q;
  assign trial    = {rem_q, dvd_q[MAG_W-1]};
  assign ge       = (trial >= {1'b0, n_q});

  // result fields known once the search is done
  always_comb begin
    res_dec = '{status: ST_OK, room_out: '0, average_out: '0, count_out: '0};
    if (mode_reg) begin
      if (hit_q || free_vld_q) res_dec.room_out = word_q.room_in;
      else                     res_dec.status   = ST_FULL;
    end else if (!hit_q) begin
      res_dec.status = ST_UNKNOWN;
    end else begin
      res_dec.room_out  = entry_room_q[idx_q];
      res_dec.count_out = mode_read ? cnt_new : cnt_cur;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_SEARCH;
      S_SEARCH: if (match || last_idx) state_d = S_DECIDE;
      S_DECIDE: state_d = (mode_read && hit_q) ? S_SUM : S_RESULT;
      S_SUM:    if (sum_done) state_d = S_DIV;
      S_DIV:    if (div_last) state_d = S_FIN;
      S_FIN:    state_d = S_RESULT;
      S_RESULT: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    store_we = 1'b0;
    entry_we = 1'b0;
    rd_en    = 1'b0;
    unique case (state_q)
      S_IDLE:   in_ready = 1'b1;
      S_DECIDE: begin
        store_we = mode_read && hit_q;
        entry_we = mode_reg && (hit_q || free_vld_q);
      end
      S_SUM:    rd_en = (rd_idx_q != n_q);
      S_RESULT: out_load = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_TEMP_RST;
      min_q <= MIN_TEMP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_TEMP: max_q <= cfg_data_i;
        REG_MIN_TEMP: min_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // per-entry control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SENSORS; i++) begin
        entry_valid_q[i] <= 1'b0;
        count_q[i]       <= '0;
        wptr_q[i]        <= '0;
      end
    end else if (entry_we) begin
      entry_valid_q[slot] <= 1'b1;
      count_q[slot]       <= '0;
      wptr_q[slot]        <= '0;
    end else if (store_we) begin
      count_q[idx_q] <= cnt_new;
      wptr_q[idx_q]  <= wptr_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      entry_sensor_q[slot] <= word_q.sensor_in;
      entry_room_q[slot]   <= word_q.room_in;
    end
  end

  // reading store
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[wr_addr] <= word_q.reading_in;
    end
    if (rd_en) begin
      rd_data_q <= store_q[rd_addr];
    end
  end

  // search and sequencing control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      free_q     <= '0;
      hit_q      <= 1'b0;
      free_vld_q <= 1'b0;
      rd_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
      step_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          idx_q      <= '0;
          hit_q      <= 1'b0;
          free_vld_q <= 1'b0;
        end
        S_SEARCH: begin
          if (match) begin
            hit_q <= 1'b1;
          end else begin
            if (!entry_valid_q[idx_q] && !free_vld_q) begin
              free_q     <= idx_q;
              free_vld_q <= 1'b1;
            end
            if (!last_idx) idx_q <= idx_q + IDX_W'(1);
          end
        end
        S_DECIDE: begin
          rd_idx_q <= '0;
          rd_vld_q <= 1'b0;
        end
        S_SUM: begin
          rd_vld_q <= rd_en;
          if (rd_en) rd_idx_q <= rd_idx_q + CNT_W'(1);
          if (sum_done) step_q <= DIV_CNT_W'(MAG_W - 1);
        end
        S_DIV:  step_q <= step_q - DIV_CNT_W'(1);
        default: ;
      endcase
    end
  end

  // datapath: capture, accumulate, divide, result
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) word_q <= in_word_i;
      end
      S_DECIDE: begin
        res_q <= res_dec;
        acc_q <= '0;
        hi_q  <= '0;
        lo_q  <= '0;
        n_q   <= cnt_new;
      end
      S_SUM: begin
        if (rd_vld_q) begin
          acc_q <= acc_q + SUM_W'(rd_data_q);
          hi_q  <= hi_q + SUM_W'(max_q);
          lo_q  <= lo_q + SUM_W'(min_q);
        end
        if (sum_done) begin
          dvd_q <= acc_mag;
          neg_q <= acc_q[SUM_W-1];
          rem_q <= '0;
          if (acc_q > hi_q)      res_q.status <= ST_HOT;
          else if (acc_q < lo_q) res_q.status <= ST_COLD;
          else                   res_q.status <= ST_OK;
        end
      end
      S_DIV: begin
        rem_q <= ge ? CNT_W'(trial - {1'b0, n_q}) : trial[CNT_W-1:0];
        dvd_q <= {dvd_q[MAG_W-2:0], ge};
      end
      S_FIN: begin
        res_q.average_out <= neg_q ? quo_neg[DATA_W-1:0] : dvd_q[DATA_W-1:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res_q;
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // checks
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> n_q != '0)
    else $error("divider started with zero count");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DECIDE |-> cnt_cur <= CNT_W'(WINDOW))
    else $error("reading count beyond window");

  a_unknown_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_UNKNOWN |->
      out_word_o.room_out == '0 && out_word_o.count_out == '0 &&
      out_word_o.average_out == '0)
    else $error("unknown sensor word carries data");

  a_thresh_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_HOT || out_word_o.status == ST_COLD) |->
      out_word_o.count_out != '0)
    else $error("threshold status without readings");

  a_load_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESULT && !out_free |=> state_q == S_RESULT)
    else $error("result dropped while output busy");

endmodule
